### hdl/edcd_pkg.sv
`default_nettype none

package edcd_pkg;

    // samples per batch, also the depth of the averaging window
    localparam int WINDOW = 5;

    localparam int ECHO_W = 20;
    localparam int HALF_W = ECHO_W - 1;
    localparam int SCALE_W = 16;
    localparam int MM_W = 12;
    localparam int POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int SUM_W = MM_W + $clog2(WINDOW);

    // divide by WINDOW as multiply by rounded-up reciprocal, exact for any SUM_W-bit sum
    localparam int DIV_SHIFT = 22;
    localparam int DIV_MULT_W = DIV_SHIFT + 1;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'((1 << DIV_SHIFT) / WINDOW + 1);

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_Q16 = 2'd2;

    localparam logic [MM_W-1:0] CLAMP_RESET = 12'd1200;
    localparam logic [MM_W-1:0] THRESHOLD_RESET = 12'd150;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd22715;

    typedef struct packed {
        logic [MM_W-1:0]    clamp_limit;
        logic [MM_W-1:0]    change_threshold;
        logic [SCALE_W-1:0] scale_q16;
    } t_cfg;

    typedef struct packed {
        logic            valid;
        logic [MM_W-1:0] mm;
    } t_sample;

endpackage

`default_nettype wire

### hdl/edcd_front.sv
`default_nettype none

module edcd_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire edcd_pkg::t_cfg               i_cfg,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [edcd_pkg::ECHO_W-1:0]  i_echo_us,
    output edcd_pkg::t_sample                 o_push,
    input  wire logic                         i_full
);
    import edcd_pkg::*;

    localparam int PROD_W = HALF_W + SCALE_W;

    logic                 r_vld;
    logic [HALF_W-1:0]    r_mm_raw;
    logic [PROD_W-1:0]    w_prod;
    logic                 w_take;

    assign o_ready = !r_vld || !i_full;
    assign w_take = i_valid && o_ready;
    assign w_prod = PROD_W'(i_echo_us[ECHO_W-1:1]) * PROD_W'(i_cfg.scale_q16);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
        if (w_take) begin
            r_mm_raw <= w_prod[PROD_W-1:SCALE_W];
        end
    end

    // saturate at the clamp limit on the way into the queue
    always_comb begin
        o_push.valid = r_vld && !i_full;
        if (r_mm_raw > HALF_W'(i_cfg.clamp_limit)) begin
            o_push.mm = i_cfg.clamp_limit;
        end else begin
            o_push.mm = r_mm_raw[MM_W-1:0];
        end
    end

endmodule

`default_nettype wire

### hdl/edcd_fifo.sv
`default_nettype none

module edcd_fifo (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire edcd_pkg::t_sample            i_push,
    output logic                              o_full,
    input  wire logic                         i_pop,
    output logic                              o_empty,
    output logic [edcd_pkg::MM_W-1:0]         o_mm
);
    import edcd_pkg::*;

    logic [MM_W-1:0]    r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_count;
    logic               w_pop;

    assign o_full = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_mm = r_mem[r_rd_ptr];
    assign w_pop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count <= '0;
        end else begin
            if (i_push.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push.valid && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push.valid && w_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push.valid) begin
            r_mem[r_wr_ptr] <= i_push.mm;
        end
    end

endmodule

`default_nettype wire

### hdl/edcd_back.sv
`default_nettype none

module edcd_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire edcd_pkg::t_cfg               i_cfg,
    input  wire logic                         i_empty,
    input  wire logic [edcd_pkg::MM_W-1:0]    i_mm,
    output logic                              o_pop,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic [edcd_pkg::MM_W-1:0]         o_average_mm,
    output logic                              o_changed
);
    import edcd_pkg::*;

    localparam int PROD_W = SUM_W + DIV_MULT_W;

    logic                 w_en;
    logic                 w_last;
    logic [SUM_W-1:0]     w_sum;
    logic [PROD_W-1:0]    w_prod;
    logic [MM_W-1:0]      w_diff;
    logic                 w_changed;

    logic [POS_W-1:0]     r_pos;
    logic [SUM_W-1:0]     r_acc;
    logic                 r_sum_vld;
    logic [SUM_W-1:0]     r_sum;
    logic                 r_avg_vld;
    logic [MM_W-1:0]      r_avg;
    logic [MM_W-1:0]      r_prev;

    // whole back pipeline moves only while the output register can take a result
    assign w_en = !o_valid || i_ready;
    assign o_pop = w_en && !i_empty;
    assign w_last = (r_pos == POS_W'(WINDOW - 1));
    assign w_sum = r_acc + SUM_W'(i_mm);
    assign w_prod = PROD_W'(r_sum) * PROD_W'(DIV_MULT);

    // the batch always spans the whole window, so the ring total equals the batch sum
    always_comb begin
        if (r_prev > r_avg) begin
            w_diff = r_prev - r_avg;
        end else begin
            w_diff = r_avg - r_prev;
        end
        w_changed = (w_diff >= i_cfg.change_threshold) && (r_prev != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_acc <= '0;
            r_sum_vld <= 1'b0;
            r_avg_vld <= 1'b0;
            r_prev <= '0;
            o_valid <= 1'b0;
        end else if (w_en) begin
            r_sum_vld <= o_pop && w_last;
            if (o_pop) begin
                if (w_last) begin
                    r_pos <= '0;
                    r_acc <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                    r_acc <= w_sum;
                end
            end
            r_avg_vld <= r_sum_vld;
            o_valid <= r_avg_vld;
            if (r_avg_vld) begin
                r_prev <= w_changed ? '0 : r_avg;
            end
        end
        if (w_en) begin
            if (o_pop && w_last) begin
                r_sum <= w_sum;
            end
            if (r_sum_vld) begin
                r_avg <= w_prod[DIV_SHIFT +: MM_W];
            end
            if (r_avg_vld) begin
                o_average_mm <= r_avg;
                o_changed <= w_changed;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/echo_distance_change_detector.sv
`default_nettype none

// echo distance change detector
// slave stream: one echo width in microseconds per transaction; master stream: one
// result per WINDOW accepted echoes with the batch mean distance and a change flag.
// the front stage scales the half echo by scale_q16 and saturates at clamp_limit;
// a four-entry queue decouples it from the back stage that sums the batch, divides
// by WINDOW with a reciprocal multiply and compares against the previous mean.
// throughput: one echo per cycle while the master side keeps up. the batch's last echo
// goes through the front register, the queue, then sum, divide and compare into the output.
// when the master side stalls, the back stage holds; the queue then fills and
// s_axis_tready falls after it and the front register are full.
// configuration: i_cfg_we writes register i_cfg_idx (0 clamp_limit, 1
// change_threshold, 2 scale_q16) from i_cfg_data; other indexes are ignored.
// reset restores 1200 / 150 / 22715, clears the batch and the previous mean.
module echo_distance_change_detector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [23:0]                       i_s_axis_tdata,  // echo_us[19:0]
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic [15:0]                            o_m_axis_tdata,  // average_mm[11:0], changed
    input  wire logic                              i_cfg_we,
    input  wire logic [edcd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [edcd_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import edcd_pkg::*;

    t_cfg            r_cfg;
    t_sample         w_push;
    logic            w_full;
    logic            w_empty;
    logic            w_pop;
    logic [MM_W-1:0] w_fifo_mm;
    logic [MM_W-1:0] w_average_mm;
    logic            w_changed;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clamp_limit <= CLAMP_RESET;
            r_cfg.change_threshold <= THRESHOLD_RESET;
            r_cfg.scale_q16 <= SCALE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CLAMP_LIMIT: begin
                    r_cfg.clamp_limit <= i_cfg_data[MM_W-1:0];
                end
                CFG_CHANGE_THRESHOLD: begin
                    r_cfg.change_threshold <= i_cfg_data[MM_W-1:0];
                end
                CFG_SCALE_Q16: begin
                    r_cfg.scale_q16 <= i_cfg_data[SCALE_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    edcd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_valid   (i_s_axis_tvalid),
        .o_ready   (o_s_axis_tready),
        .i_echo_us (i_s_axis_tdata[ECHO_W-1:0]),
        .o_push    (w_push),
        .i_full    (w_full)
    );

    edcd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_mm    (w_fifo_mm)
    );

    edcd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_empty      (w_empty),
        .i_mm         (w_fifo_mm),
        .o_pop        (w_pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_average_mm (w_average_mm),
        .o_changed    (w_changed)
    );

    assign o_m_axis_tdata = {3'b000, w_changed, w_average_mm};

endmodule

`default_nettype wire

### sim/echo_distance_change_detector_test.sv
`timescale 1ns / 1ps

module echo_distance_change_detector_test;
    import edcd_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic            changed;
        logic [MM_W-1:0] average_mm;
    } t_batch_mean;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
    localparam int SETTLE_CYCLES = 20;
    localparam int STALL_LIMIT = 2000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [23:0]           s_data = '0;   // echo_us[19:0]
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [15:0]           m_data;        // average_mm[11:0], changed
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // predictor copy of the registers
    logic [MM_W-1:0]    clamp_mm = CLAMP_RESET;
    logic [MM_W-1:0]    thresh_mm = THRESHOLD_RESET;
    logic [SCALE_W-1:0] scale_q = SCALE_RESET;

    // predictor copy of the averaging state
    logic [MM_W-1:0] ring_mm [WINDOW] = '{default: '0};
    int              ring_slot = 0;
    int              ring_sum = 0;
    int              ring_fill = 0;
    int              batch_pos = 0;
    logic [MM_W-1:0] last_mean = '0;

    logic [23:0]   echo_q [$];
    t_batch_mean   mean_q [$];
    t_batch_mean   want_mean;
    int            send_idle_pct = 0;
    int            recv_stall_pct = 0;
    int            fail_count = 0;
    int            quiet_cycles = 0;

    echo_distance_change_detector u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_idx       (cfg_idx),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // scale, clamp and push one echo; every WINDOW echoes yields a batch mean
    task automatic absorb_echo(input logic [ECHO_W-1:0] echo);
        logic [HALF_W-1:0]         half;
        logic [HALF_W+SCALE_W-1:0] product;
        logic [HALF_W-1:0]         scaled;
        logic [MM_W-1:0]           mm;
        logic [MM_W-1:0]           mean;
        logic [MM_W-1:0]           gap;
        logic                      moved;
        half = echo[ECHO_W-1:1];
        product = half * scale_q;
        scaled = product[HALF_W+SCALE_W-1:SCALE_W];
        mm = (scaled > clamp_mm) ? clamp_mm : scaled[MM_W-1:0];
        ring_sum = ring_sum - ring_mm[ring_slot] + mm;
        ring_mm[ring_slot] = mm;
        ring_slot = (ring_slot + 1) % WINDOW;
        if (ring_fill < WINDOW) ring_fill++;
        batch_pos++;
        if (batch_pos == WINDOW) begin
            batch_pos = 0;
            mean = (ring_fill == 0) ? '0 : MM_W'(ring_sum / ring_fill);
            gap = (last_mean > mean) ? last_mean - mean : mean - last_mean;
            moved = (gap >= thresh_mm) && (last_mean != 0);
            // a reported change clears the reference so the next batch cannot flag
            last_mean = moved ? '0 : mean;
            mean_q.push_back('{changed: moved, average_mm: mean});
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) absorb_echo(s_data[ECHO_W-1:0]);
            if (!s_valid || s_ready) begin
                if (echo_q.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_data <= echo_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (mean_q.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", m_data);
                    fail_count++;
                end else begin
                    want_mean = mean_q.pop_front();
                    if (m_data[MM_W-1:0] !== want_mean.average_mm) begin
                        $error("average_mm mismatch: expected %0d, actual %0d",
                               want_mean.average_mm, m_data[MM_W-1:0]);
                        fail_count++;
                    end
                    if (m_data[MM_W] !== want_mean.changed) begin
                        $error("changed mismatch: expected %0d, actual %0d",
                               want_mean.changed, m_data[MM_W]);
                        fail_count++;
                    end
                end
            end
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("echo_distance_change_detector_test: FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic void queue_echo(input logic [ECHO_W-1:0] echo);
        // padding bits above the field get random values, the block ignores them
        echo_q.push_back({4'($urandom), echo});
    endfunction

    // largest echo that still lands a bit above the clamp with current scale
    function automatic logic [ECHO_W-1:0] echo_span();
        longint reach;
        if (scale_q == 0) return '1;
        reach = (longint'(clamp_mm) * 4 / 3 + 8) * 65536 / longint'(scale_q) * 2 + 1;
        return (reach > longint'(20'hFFFFF)) ? '1 : ECHO_W'(reach);
    endfunction

    task automatic fill_echoes(input int count);
        int                pushed;
        int                pick;
        int                level;
        logic [ECHO_W-1:0] span;
        logic [ECHO_W-1:0] base;
        logic [ECHO_W-1:0] jitter;
        pushed = 0;
        span = echo_span();
        jitter = span >> 5;
        base = ECHO_W'($urandom_range(0, span));
        while (pushed < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
                // batch around one level, often a new level, sometimes a repeat
                if ($urandom_range(0, 2) != 0) base = ECHO_W'($urandom_range(0, span));
                for (int k = 0; k < WINDOW; k++) begin
                    level = int'(base) + int'($urandom_range(0, jitter));
                    queue_echo((level > 'hFFFFF) ? '1 : ECHO_W'(level));
                end
                pushed += WINDOW;
            end else if (pick < 85) begin
                for (int k = 0; k < WINDOW; k++) queue_echo(ECHO_W'($urandom));
                pushed += WINDOW;
            end else if (pick < 98) begin
                for (int k = 0; k < WINDOW; k++)
                    queue_echo($urandom_range(0, 1) ? '1 : ECHO_W'($urandom_range(0, 3)));
                pushed += WINDOW;
            end else begin
                // lone echo shifts the batch boundary against the levels
                queue_echo(ECHO_W'($urandom));
                pushed++;
            end
        end
    endtask

    task automatic wait_drained();
        while (echo_q.size() != 0 || s_valid || mean_q.size() != 0) @(posedge i_clk);
        // echoes of an incomplete batch may still be in flight
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle(input t_idle_mode mode);
        case (mode)
            IDLE_NONE: begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            IDLE_SEND: begin
                send_idle_pct = 79;
                recv_stall_pct = 0;
            end
            IDLE_RECV: begin
                send_idle_pct = 0;
                recv_stall_pct = 79;
            end
            default: begin
                send_idle_pct = 8;
                recv_stall_pct = 8;
            end
        endcase
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        case (idx)
            CFG_CLAMP_LIMIT:      clamp_mm = data[MM_W-1:0];
            CFG_CHANGE_THRESHOLD: thresh_mm = data[MM_W-1:0];
            CFG_SCALE_Q16:        scale_q = data[SCALE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic write_config(input logic [MM_W-1:0] clamp, input logic [MM_W-1:0] thresh,
                                input logic [SCALE_W-1:0] scale);
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'($urandom));
        write_reg(CFG_CLAMP_LIMIT, {4'($urandom), clamp});
        write_reg(CFG_CHANGE_THRESHOLD, {4'($urandom), thresh});
        write_reg(CFG_SCALE_Q16, scale);
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_config();
        logic [MM_W-1:0] clamp;
        logic [MM_W-1:0] thresh;
        clamp = MM_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                  : $urandom_range(200, 2000));
        thresh = MM_W'($urandom_range(0, 1) ? $urandom_range(1, 300)
                                            : $urandom_range(0, 4095));
        write_config(clamp, thresh, SCALE_W'($urandom));
    endtask

    task automatic run_phase(input t_idle_mode mode, input int count);
        set_idle(mode);
        fill_echoes(count);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: zero reference, saturation, a change, then the cleared
        // reference and a small move that stays below threshold
        set_idle(IDLE_NONE);
        queue_echo(20'd0);
        queue_echo(20'd1);
        queue_echo(20'd2);
        queue_echo(20'd3);
        queue_echo(20'd0);
        repeat (WINDOW) queue_echo(20'hFFFFF);
        repeat (WINDOW) queue_echo(20'd3000);
        repeat (WINDOW) queue_echo(20'd3000);
        repeat (WINDOW) queue_echo(20'd3500);
        wait_drained();

        run_phase(IDLE_NONE, 250);
        write_config(12'd4095, 12'd0, 16'hFFFF);
        run_phase(IDLE_SEND, 250);
        write_config(12'd0, 12'd4095, 16'd0);
        run_phase(IDLE_RECV, 200);
        random_config();
        run_phase(IDLE_BOTH, 250);
        write_config(12'd4095, 12'd4095, 16'hFFFF);
        run_phase(IDLE_NONE, 200);
        random_config();
        run_phase(IDLE_SEND, 250);
        random_config();
        run_phase(IDLE_RECV, 250);
        random_config();
        run_phase(IDLE_BOTH, 200);

        if (fail_count == 0 && mean_q.size() == 0) begin
            $display("echo_distance_change_detector_test: PASS");
        end else begin
            $display("echo_distance_change_detector_test: FAIL");
        end
        $finish;
    end

endmodule
